@@ design/filter_bank_best_match_top_macros.svh @@
`ifndef FILTER_BANK_BEST_MATCH_TOP_MACROS_SVH
`define FILTER_BANK_BEST_MATCH_TOP_MACROS_SVH

// same-cycle implication
`define FBBM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define FBBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/fbbm_pkg.sv @@
package fbbm_pkg;

   localparam int FILTER_COUNT = 100;
   localparam int WINDOW_SIDE  = 3;
   localparam int TAPS         = WINDOW_SIDE * WINDOW_SIDE;
   localparam int MAX_WIDTH    = 2048;
   localparam int HEIGHT_LIMIT = 2048;
   localparam int COEFF_COUNT  = FILTER_COUNT * TAPS;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(HEIGHT_LIMIT);
   localparam int FIL_W = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
   localparam int CFG_W = 12;
   localparam int CMP_W = ((COL_W + 1) > CFG_W) ? (COL_W + 1) : CFG_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_COEFF = 1'b1;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
   localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

   typedef struct packed {
      logic              opcode;
      logic signed [15:0] pixel_value;
      logic [9:0]        coeff_index;
      logic signed [15:0] coeff_value;
   } req_type;

   typedef struct packed {
      logic [10:0] center_row;
      logic [10:0] center_col;
      logic [6:0]  best_filter;
      logic [33:0] best_magnitude;
   } rsp_type;

   typedef struct packed {
      logic             pix_take;
      logic             coef_take;
      logic             line_step;
      logic             issue;
      logic [FIL_W-1:0] issue_idx;
      logic             rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic pipe_busy;
      logic rsp_free;
   } dp_sts_type;

endpackage

@@ design/fbbm_ram.sv @@
module fbbm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ design/fbbm_ctrl.sv @@
module fbbm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_opcode,
   output logic                req_ready,
   input  fbbm_pkg::dp_sts_type sts,
   output fbbm_pkg::dp_cmd_type cmd
);
   import fbbm_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_STEP  = 3'd2;
   localparam logic [2:0] S_RUN   = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [FIL_W-1:0] fil_ff, fil_in;

   always_comb begin
      state_in = state_ff;
      fil_in   = fil_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_PIXEL) begin
                  cmd.pix_take = 1'b1;
                  state_in = S_READ;
               end else begin
                  cmd.coef_take = 1'b1;
               end
            end
         end
         S_READ: state_in = S_STEP;
         S_STEP: begin
            cmd.line_step = 1'b1;
            fil_in = '0;
            state_in = sts.emit ? S_RUN : S_IDLE;
         end
         S_RUN: begin
            cmd.issue     = 1'b1;
            cmd.issue_idx = fil_ff;
            fil_in = fil_ff + FIL_W'(1);
            if (fil_ff == FIL_W'(FILTER_COUNT - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fil_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fil_ff   <= fil_in;
      end
   end
endmodule

@@ design/fbbm_dp.sv @@
module fbbm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  fbbm_pkg::req_type             req_data,
   input  logic                          csr_we,
   input  logic [fbbm_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [fbbm_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output fbbm_pkg::rsp_type             rsp_data,
   input  fbbm_pkg::dp_cmd_type          cmd,
   output fbbm_pkg::dp_sts_type          sts
);
   import fbbm_pkg::*;

   // configuration
   logic [CFG_W-1:0] width_ff, height_ff;
   logic [CMP_W-1:0] w_lim, h_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_we) begin
         case (csr_addr)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_lim = CMP_W'(width_ff);
      if (w_lim < CMP_W'(3)) w_lim = CMP_W'(3);
      else if (w_lim > CMP_W'(MAX_WIDTH)) w_lim = CMP_W'(MAX_WIDTH);
      h_lim = CMP_W'(height_ff);
      if (h_lim < CMP_W'(3)) h_lim = CMP_W'(3);
      else if (h_lim > CMP_W'(HEIGHT_LIMIT)) h_lim = CMP_W'(HEIGHT_LIMIT);
   end

   // position counters
   logic [COL_W-1:0] col_ff, col_in, cur_c_ff;
   logic [ROW_W-1:0] row_ff, row_in, cur_r_ff;
   logic [CMP_W-1:0] c_next, r_next;
   logic signed [15:0] px_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      c_next = CMP_W'(cur_c_ff) + CMP_W'(1);
      r_next = CMP_W'(cur_r_ff) + CMP_W'(1);
      if (cmd.line_step) begin
         if (c_next >= w_lim) begin
            col_in = '0;
            row_in = (r_next >= h_lim) ? '0 : ROW_W'(r_next);
         end else begin
            col_in = COL_W'(c_next);
            row_in = cur_r_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // wrap stale counters on take
   always_ff @(posedge clock) begin
      if (cmd.pix_take) begin
         cur_c_ff <= (CMP_W'(col_ff) >= w_lim) ? '0 : col_ff;
         cur_r_ff <= (CMP_W'(row_ff) >= h_lim) ? '0 : row_ff;
         px_ff    <= req_data.pixel_value;
      end
   end

   assign sts.emit = (cur_r_ff >= ROW_W'(2)) && (cur_c_ff >= COL_W'(2));

   // line stores
   logic [15:0] up_rd, mid_rd;

   fbbm_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .we(cmd.line_step), .waddr(cur_c_ff), .wdata(mid_rd),
      .raddr(cur_c_ff), .rdata(up_rd)
   );

   fbbm_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_middle (
      .clock(clock), .we(cmd.line_step), .waddr(cur_c_ff), .wdata(px_ff),
      .raddr(cur_c_ff), .rdata(mid_rd)
   );

   // window
   logic signed [15:0] win_ff [TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) win_ff[k] <= '0;
      end else if (cmd.line_step) begin
         for (int k = 0; k < WINDOW_SIDE; k++) begin
            win_ff[k*WINDOW_SIDE]     <= win_ff[k*WINDOW_SIDE + 1];
            win_ff[k*WINDOW_SIDE + 1] <= win_ff[k*WINDOW_SIDE + 2];
         end
         win_ff[2] <= $signed(up_rd);
         win_ff[5] <= $signed(mid_rd);
         win_ff[8] <= px_ff;
      end
   end

   // coefficient index split: filter = index / 9, tap = index % 9
   logic [18:0]      q_prod;
   logic [9:0]       q_est, r_est;
   logic [9:0]       q_fix, r_fix;
   logic             idx_ok;

   always_comb begin
      q_prod = 19'(req_data.coeff_index) * 19'(455);
      q_est  = 10'(q_prod[18:12]);
      r_est  = req_data.coeff_index - 10'(q_est * 10'(TAPS));
      if (r_est >= 10'(TAPS)) begin
         q_fix = q_est + 10'(1);
         r_fix = r_est - 10'(TAPS);
      end else begin
         q_fix = q_est;
         r_fix = r_est;
      end
      idx_ok = 11'(req_data.coeff_index) < 11'(COEFF_COUNT);
   end

   logic [15:0] coef_rd [TAPS];

   for (genvar t = 0; t < TAPS; t++) begin : g_tap
      fbbm_ram #(.WIDTH(16), .DEPTH(FILTER_COUNT)) u_coef (
         .clock(clock),
         .we(cmd.coef_take && idx_ok && (r_fix == 10'(t))),
         .waddr(FIL_W'(q_fix)),
         .wdata(req_data.coeff_value),
         .raddr(cmd.issue_idx),
         .rdata(coef_rd[t])
      );
   end

   // multiply-accumulate pipeline, one filter per cycle
   logic               v0_ff, v1_ff, v2_ff, v3_ff;
   logic [FIL_W-1:0]   f0_ff, f1_ff, f2_ff, f3_ff;
   logic signed [31:0] prod_ff [TAPS];
   logic signed [33:0] part_ff [WINDOW_SIDE];
   logic signed [35:0] sum_ff;
   logic [35:0]        sum_abs;
   logic [33:0]        mag;
   logic [33:0]        best_mag_ff;
   logic [FIL_W-1:0]   best_fil_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      f0_ff <= cmd.issue_idx;
      f1_ff <= f0_ff;
      f2_ff <= f1_ff;
      f3_ff <= f2_ff;
      for (int k = 0; k < TAPS; k++) begin
         prod_ff[k] <= win_ff[k] * $signed(coef_rd[k]);
      end
      for (int j = 0; j < WINDOW_SIDE; j++) begin
         part_ff[j] <= 34'(prod_ff[j*WINDOW_SIDE]) + 34'(prod_ff[j*WINDOW_SIDE + 1])
                     + 34'(prod_ff[j*WINDOW_SIDE + 2]);
      end
      sum_ff <= 36'(part_ff[0]) + 36'(part_ff[1]) + 36'(part_ff[2]);
   end

   always_comb begin
      sum_abs = sum_ff[35] ? 36'(-sum_ff) : 36'(sum_ff);
      mag     = sum_abs[33:0];
   end

   // lower index wins ties
   always_ff @(posedge clock) begin
      if (v3_ff && ((f3_ff == '0) || (mag > best_mag_ff))) begin
         best_mag_ff <= mag;
         best_fil_ff <= f3_ff;
      end
   end

   assign sts.pipe_busy = v0_ff | v1_ff | v2_ff | v3_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.center_row     <= 11'(cur_r_ff - ROW_W'(1));
         rsp_ff.center_col     <= 11'(cur_c_ff - COL_W'(1));
         rsp_ff.best_filter    <= 7'(best_fil_ff);
         rsp_ff.best_magnitude <= best_mag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

@@ design/filter_bank_best_match_top.sv @@
// Streaming 3x3 filter bank: for each interior pixel, reports the filter with the
// largest absolute response over the window centered one row up and one column
// left, and that magnitude. A coefficient write leaves the controller idle and
// ready for the next item. A border pixel goes through accept, line-store read and
// window update. An interior pixel goes through accept, line-store read, window
// update, one filter per cycle through the nine-multiplier dot-product pipeline,
// draining that pipeline and loading the output register; that single shared
// pipeline sets the rate. The load waits while an earlier result is still held in
// the output register and not being taken. A finished result waits in the output
// register while the next item is accepted.
module filter_bank_best_match_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fbbm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fbbm_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [fbbm_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [fbbm_pkg::CFG_W-1:0]    csr_wdata
);
   import fbbm_pkg::*;

`include "filter_bank_best_match_top_macros.svh"

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       pix_accept;

   fbbm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_opcode(req_data.opcode), .req_ready(req_ready), .sts(sts), .cmd(cmd)
   );

   fbbm_dp u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .csr_we(csr_we),
      .csr_addr(csr_addr), .csr_wdata(csr_wdata), .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .cmd(cmd), .sts(sts)
   );

   assign pix_accept = req_valid && req_ready && (req_data.opcode == OP_PIXEL);

   `FBBM_ASSERT_NEXT(a_pixel_busy, clock, reset, pix_accept, !req_ready)
   `FBBM_ASSERT_NOW(a_load_free, clock, reset, cmd.rsp_load, sts.rsp_free)
   `FBBM_ASSERT_NOW(a_pipe_closed, clock, reset, sts.pipe_busy, !req_ready)
endmodule

@@ tb/filter_bank_best_match_top_test.sv @@
`default_nettype none

module filter_bank_best_match_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fbbm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = CSR_IDX_W'(3);
   localparam int SETTLE_CYCLES = 130;
   localparam int RANDOM_ITEMS = 600;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_addr;
   logic [CFG_W-1:0]     csr_wdata;

   // predictor state
   logic [CFG_W-1:0]   width_cfg;
   logic [CFG_W-1:0]   height_cfg;
   logic signed [15:0] upper_mem [MAX_WIDTH];
   logic signed [15:0] middle_mem [MAX_WIDTH];
   logic signed [15:0] window_mem [TAPS];
   logic signed [15:0] coeff_mem [COEFF_COUNT];
   int                 col_pos;
   int                 row_pos;

   rsp_type      pending_matches[$];
   stim_row_type directed_rows[$];
   int           error_count;
   int           hold_cycles;
   bit           no_idle;
   int           sent_items;

   filter_bank_best_match_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report(input string what, input longint want, input longint got);
      $display("mismatch %s: expected %0d, got %0d (at %0t)", what, want, got, $realtime);
      error_count++;
   endtask

   task automatic predict_best_match(input req_type it, output bit has, output rsp_type res);
      int     w;
      int     h;
      int     c;
      int     r;
      longint sum;
      longint mag;
      longint best_mag;
      int     best;
      has = 1'b0;
      res = '0;
      if (it.opcode == OP_COEFF) begin
         if (it.coeff_index < COEFF_COUNT) coeff_mem[it.coeff_index] = it.coeff_value;
         return;
      end
      w = (width_cfg < 3) ? 3 : (width_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(width_cfg);
      h = (height_cfg < 3) ? 3 : (height_cfg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_cfg);
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      for (int k = 0; k < WINDOW_SIDE; k++) begin
         window_mem[k*WINDOW_SIDE]   = window_mem[k*WINDOW_SIDE+1];
         window_mem[k*WINDOW_SIDE+1] = window_mem[k*WINDOW_SIDE+2];
      end
      window_mem[2] = upper_mem[c];
      window_mem[5] = middle_mem[c];
      window_mem[8] = it.pixel_value;
      upper_mem[c]  = middle_mem[c];
      middle_mem[c] = it.pixel_value;
      if (r >= 2 && c >= 2) begin
         best = 0;
         best_mag = 0;
         for (int f = 0; f < FILTER_COUNT; f++) begin
            sum = 0;
            for (int k = 0; k < TAPS; k++)
               sum += longint'(window_mem[k]) * longint'(coeff_mem[f*TAPS+k]);
            mag = (sum < 0) ? -sum : sum;
            if (f == 0 || mag > best_mag) begin
               best_mag = mag;
               best = f;
            end
         end
         has = 1'b1;
         res.center_row = 11'(r - 1);
         res.center_col = 11'(c - 1);
         res.best_filter = 7'(best);
         res.best_magnitude = 34'(best_mag);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   // returns right after the accepting edge, with valid still high
   task automatic send_item(input req_type it, input bit typed = 1'b0,
                            input rsp_type want = '0);
      int      gap;
      bit      has;
      rsp_type res;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = it;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_best_match(it, has, res);
      if (has) pending_matches.push_back(typed ? want : res);
      sent_items++;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == REG_IMAGE_WIDTH) width_cfg = value;
      else if (idx == REG_IMAGE_HEIGHT) height_cfg = value;
   endtask

   function automatic req_type pixel_item(input logic signed [15:0] v);
      req_type it;
      it = '0;
      it.opcode = OP_PIXEL;
      it.pixel_value = v;
      return it;
   endfunction

   function automatic req_type coeff_item(input int idx, input logic signed [15:0] v);
      req_type it;
      it = '0;
      it.opcode = OP_COEFF;
      it.coeff_index = 10'(idx);
      it.coeff_value = v;
      return it;
   endfunction

   function automatic void add_row(input req_type it, input bit typed = 1'b0,
                                   input int row = 0, input int col = 0,
                                   input int filt = 0, input longint mag = 0);
      stim_row_type s;
      s.item = it;
      s.typed = typed;
      s.want = '{center_row: 11'(row), center_col: 11'(col),
                 best_filter: 7'(filt), best_magnitude: 34'(mag)};
      directed_rows.push_back(s);
   endfunction

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   // result check
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_matches.size() == 0) begin
               report("unexpected transfer", 0, 1);
            end else begin
               want = pending_matches.pop_front();
               if (rsp_data.center_row !== want.center_row)
                  report("center_row", want.center_row, rsp_data.center_row);
               if (rsp_data.center_col !== want.center_col)
                  report("center_col", want.center_col, rsp_data.center_col);
               if (rsp_data.best_filter !== want.best_filter)
                  report("best_filter", want.best_filter, rsp_data.best_filter);
               if (rsp_data.best_magnitude !== want.best_magnitude)
                  report("best_magnitude", want.best_magnitude, rsp_data.best_magnitude);
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int w;
      int h;
      int frames;
      int rand_start;
      error_count = 0;
      hold_cycles = 0;
      no_idle = 1'b0;
      sent_items = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      width_cfg = RESET_WIDTH;
      height_cfg = RESET_HEIGHT;
      col_pos = 0;
      row_pos = 0;
      foreach (upper_mem[i]) begin
         upper_mem[i] = '0;
         middle_mem[i] = '0;
      end
      foreach (window_mem[i]) window_mem[i] = '0;
      foreach (coeff_mem[i]) coeff_mem[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // below the minimum: both clamp to 3
      write_reg(REG_IMAGE_WIDTH, 12'd2);
      write_reg(REG_IMAGE_HEIGHT, 12'd0);
      write_reg(REG_UNUSED, 12'd5);
      for (int i = 0; i < COEFF_COUNT; i++) send_item(coeff_item(i, 16'sd0));

      // all-zero bank: filter 0 wins with zero magnitude
      add_row(pixel_item(16'sh8000));
      add_row(pixel_item(16'sh7fff));
      add_row(pixel_item(16'sd0));
      add_row(pixel_item(16'sd1));
      add_row(pixel_item(-16'sd1));
      add_row(pixel_item(16'sh5555));
      add_row(pixel_item(16'shaaaa));
      add_row(pixel_item(16'sd123));
      add_row(pixel_item(16'sd77), 1'b1, 1, 1, 0, 0);
      add_row(coeff_item(4, 16'sh8000));
      add_row(coeff_item(COEFF_COUNT - 1, 16'sh7fff));
      add_row(coeff_item(COEFF_COUNT, 16'sd5));      // out of range: dropped
      add_row(coeff_item(1023, -16'sd1));
      add_row(coeff_item(3*TAPS + 4, 16'sh8000));   // ties filter 0
      add_row(coeff_item(TAPS + 4, 16'sd16384));
      for (int i = 0; i < 9; i++) add_row(pixel_item(i[0] ? 16'sh7fff : 16'sh8000));
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      // largest magnitude: every tap and pixel at the negative extreme
      for (int k = 0; k < TAPS; k++) send_item(coeff_item(50*TAPS + k, 16'sh8000));
      for (int i = 0; i < 9; i++) send_item(pixel_item(16'sh8000));
      for (int k = 0; k < TAPS; k++) send_item(coeff_item(50*TAPS + k, rand_sample()));

      rand_start = sent_items;
      for (int phase = 0; sent_items - rand_start < RANDOM_ITEMS; phase++) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 24) : $urandom_range(3, 6);
         h = $urandom_range(3, 6);
         write_reg(REG_IMAGE_WIDTH, 12'(w));
         write_reg(REG_IMAGE_HEIGHT, 12'(h));
         no_idle = (phase % 4 == 3);
         if (phase == 1) hold_cycles = 600;
         frames = $urandom_range(1, 2);
         for (int p = 0; p < w * h * frames; ) begin
            if ($urandom_range(0, 3) == 0) begin
               send_item(coeff_item($urandom_range(0, 1023), rand_sample()));
            end else begin
               send_item(pixel_item(rand_sample()));
               p++;
            end
            if ($urandom_range(0, 99) == 0) drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
